>>> src/dgf_pkg.sv
// ----------------------------------------------------------------------------
// dgf_pkg
// Shared types and constants of the decimal digit glyph formatter.
// ----------------------------------------------------------------------------
package dgf_pkg;

  localparam int MAX_SLOTS  = 16;
  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int COUNT_W    = $clog2(MAX_SLOTS + 1);
  localparam int MAX_DIGITS = 10;
  localparam int NDIG_W     = $clog2(MAX_DIGITS + 1);
  localparam int DIGIT_W    = 4;
  localparam int GLYPH_W    = 5;
  localparam int VALUE_W    = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [VALUE_W-1:0] INT_MIN    = 32'h8000_0000;
  localparam logic [GLYPH_W-1:0] NEG_OFFSET = 5'd12;

  // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for any 32-bit x
  localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_BLANK = 2'd1;
  localparam logic [1:0] MODE_FULL  = 2'd2;

  localparam logic [1:0] ALIGN_LEFT   = 2'd0;
  localparam logic [1:0] ALIGN_RIGHT  = 2'd1;
  localparam logic [1:0] ALIGN_CENTER = 2'd2;
  localparam logic [1:0] ALIGN_NONE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_MODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIDE_ZEROS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_SLOTS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_GLYPH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NEG_BLANK     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PLUS_GLYPH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MINUS_GLYPH   = 3'd7;

  typedef struct packed {
    logic load;
    logic mul;
    logic sub;
  } unit_ctl_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               q_zero;
  } unit_stat_t;

endpackage

>>> src/decimal_digit_glyph_formatter.sv
// ----------------------------------------------------------------------------
// decimal_digit_glyph_formatter
// Turns a signed 32-bit value into one glyph per display slot.
// ----------------------------------------------------------------------------
// Sequence: the shared divide-by-ten unit takes a multiply step and a
// remainder step per digit, then a finish step, then the block emits one
// result beat per slot and returns to idle; a new value is accepted only while
// idle. The shared unit produces 0..10 digits, none for zero or a single
// full-mode slot. Results cannot be stalled.
// Reset: synchronous; configuration registers, state and result_valid return to their defaults, block idle.
// ----------------------------------------------------------------------------
module decimal_digit_glyph_formatter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [dgf_pkg::VALUE_W-1:0] value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dgf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dgf_pkg::GLYPH_W-1:0]        cfg_data,
  output logic                               result_valid,
  output logic [dgf_pkg::SLOT_W-1:0]         slot,
  output logic [dgf_pkg::GLYPH_W-1:0]        glyph,
  output logic                               shown,
  output logic [dgf_pkg::COUNT_W-1:0]        digit_count,
  output logic                               last
);
  import dgf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUB  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [1:0]         number_mode;
  logic [1:0]         align_mode;
  logic               hide_leading_zeros;
  logic [COUNT_W-1:0] digit_slots;
  logic [GLYPH_W-1:0] blank_glyph;
  logic [GLYPH_W-1:0] negative_blank_glyph;
  logic [GLYPH_W-1:0] plus_glyph;
  logic [GLYPH_W-1:0] minus_glyph;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic               negative;
  logic [NDIG_W-1:0]  ndig;
  logic [DIGIT_W-1:0] digits [MAX_DIGITS];
  logic [SLOT_W-1:0]  sign_pos;
  logic               sign_en;
  logic [COUNT_W-1:0] count;
  logic [SLOT_W-1:0]  idx;

  logic [COUNT_W-1:0] slots_eff;
  logic [COUNT_W-1:0] room;
  logic               full;
  logic               accept;
  logic [VALUE_W-1:0] raw;
  logic               raw_neg;
  logic [VALUE_W-1:0] raw_mag;
  logic               last_digit;
  logic [COUNT_W-1:0] cnt;
  logic [GLYPH_W-1:0] glyph_next;
  logic               shown_next;

  unit_ctl_t  unit_ctl;
  unit_stat_t unit_stat;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign full      = (number_mode == MODE_FULL);
  assign slots_eff = (digit_slots > COUNT_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS) : digit_slots;
  assign room      = full ? slots_eff - 1'b1 : slots_eff;

  assign raw     = (value == INT_MIN) ? '0 : value;
  assign raw_neg = raw[VALUE_W-1];
  assign raw_mag = raw_neg ? (~raw + 1'b1) : raw;

  assign last_digit = unit_stat.q_zero || (COUNT_W'(ndig) + 1'b1 == room);

  assign unit_ctl.load = accept;
  assign unit_ctl.mul  = (state == ST_MUL);
  assign unit_ctl.sub  = (state == ST_SUB);

  dgf_digit_unit u_digit (
    .clk      (clk),
    .ctl      (unit_ctl),
    .load_mag (raw_mag),
    .stat     (unit_stat)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      number_mode          <= MODE_PLAIN;
      align_mode           <= ALIGN_LEFT;
      hide_leading_zeros   <= 1'b0;
      digit_slots          <= 5'd8;
      blank_glyph          <= 5'd10;
      negative_blank_glyph <= 5'd22;
      plus_glyph           <= 5'd11;
      minus_glyph          <= 5'd23;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUMBER_MODE: number_mode          <= cfg_data[1:0];
        REG_ALIGN_MODE:  align_mode           <= cfg_data[1:0];
        REG_HIDE_ZEROS:  hide_leading_zeros   <= cfg_data[0];
        REG_DIGIT_SLOTS: digit_slots          <= cfg_data;
        REG_BLANK_GLYPH: blank_glyph          <= cfg_data;
        REG_NEG_BLANK:   negative_blank_glyph <= cfg_data;
        REG_PLUS_GLYPH:  plus_glyph           <= cfg_data;
        REG_MINUS_GLYPH: minus_glyph          <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && slots_eff != '0) begin
          if (raw_mag == '0 || room == '0) begin
            state_next = ST_FIN;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: state_next = ST_SUB;
      ST_SUB: state_next = last_digit ? ST_FIN : ST_MUL;
      ST_FIN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (COUNT_W'(idx) + 1'b1 == slots_eff) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // final count and sign placement
  always_comb begin
    cnt = COUNT_W'(ndig);
    if (align_mode == ALIGN_RIGHT) begin
      if (!hide_leading_zeros || cnt == slots_eff) begin
        cnt = slots_eff - 1'b1;
      end
    end else if (cnt == slots_eff) begin
      cnt = cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      negative <= raw_neg;
      if (raw_mag == '0) begin
        digits[0] <= '0;
        ndig      <= NDIG_W'(1);
      end else begin
        ndig <= '0;
      end
    end else if (state == ST_SUB) begin
      digits[ndig] <= unit_stat.digit;
      ndig         <= ndig + 1'b1;
    end
    if (state == ST_FIN) begin
      sign_en  <= full && (align_mode != ALIGN_NONE);
      sign_pos <= cnt[SLOT_W-1:0];
      idx      <= '0;
      if (full && align_mode != ALIGN_NONE) begin
        count <= cnt + 1'b1;
      end else begin
        count <= COUNT_W'(ndig);
      end
    end else if (state == ST_EMIT) begin
      idx <= idx + 1'b1;
    end
  end

  // glyph for the current slot
  always_comb begin
    if (number_mode == MODE_BLANK) begin
      glyph_next = blank_glyph;
      shown_next = 1'b1;
    end else if (full) begin
      glyph_next = negative ? negative_blank_glyph : blank_glyph;
      shown_next = 1'b1;
    end else begin
      glyph_next = '0;
      shown_next = 1'b0;
    end
    if (NDIG_W'(idx) < ndig) begin
      glyph_next = {1'b0, digits[idx]} + ((full && negative) ? NEG_OFFSET : '0);
      shown_next = 1'b1;
    end
    if (sign_en && idx == sign_pos) begin
      glyph_next = negative ? minus_glyph : plus_glyph;
      shown_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT) begin
      slot        <= idx;
      glyph       <= glyph_next;
      shown       <= shown_next;
      digit_count <= count;
      last        <= (COUNT_W'(idx) + 1'b1 == slots_eff);
    end
  end

  // checks
  a_beat_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == ST_EMIT)
    else $error("result beat without emit step");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid)
    else $error("result beat right after last beat");

  a_slots_consecutive: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid && slot == SLOT_W'($past(slot) + 1'b1))
    else $error("slot beats not consecutive");

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> ndig <= NDIG_W'(MAX_DIGITS))
    else $error("digit count overflow");

endmodule

>>> src/dgf_digit_unit.sv
// ----------------------------------------------------------------------------
// dgf_digit_unit
// Shared divide-by-ten unit: one reciprocal multiply, then remainder and
// quotient write-back, yielding one decimal digit per multiply step and write-back step.
// ----------------------------------------------------------------------------
module dgf_digit_unit (
  input  logic                             clk,
  input  dgf_pkg::unit_ctl_t               ctl,
  input  logic [dgf_pkg::VALUE_W-1:0]      load_mag,
  output dgf_pkg::unit_stat_t              stat
);
  import dgf_pkg::*;

  logic [VALUE_W-1:0]   mag;
  logic [VALUE_W-1:0]   q;
  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   q_times_10;
  logic [VALUE_W-1:0]   rem;

  assign prod       = {{VALUE_W{1'b0}}, mag} * {{VALUE_W{1'b0}}, RECIP_10};
  assign q_times_10 = {q[VALUE_W-4:0], 3'b000} + {q[VALUE_W-2:0], 1'b0};
  assign rem        = mag - q_times_10;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mag <= load_mag;
    end else if (ctl.sub) begin
      mag <= q;
    end
    if (ctl.mul) begin
      q <= VALUE_W'(prod >> RECIP_SHIFT);
    end
  end

  assign stat.digit  = rem[DIGIT_W-1:0];
  assign stat.q_zero = (q == '0);

endmodule
